[sv/ahgp_pkg.sv]
// shared widths, register codes and divider request and response types
package ahgp_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COORD_W  = 10;
  localparam int OX_W     = 9;
  localparam int OY_W     = 9;
  localparam int AW_W     = 10;
  localparam int AH_W     = 10;
  localparam int SPAN_W   = 16;
  localparam int QUOT_W   = 10;
  localparam int DVD_W    = SPAN_W + QUOT_W;
  localparam int APB_AW   = 5;
  localparam int APB_DW   = 32;

  localparam logic [OX_W-1:0]   ORIGIN_X_RST = 9'd0;
  localparam logic [OY_W-1:0]   ORIGIN_Y_RST = 9'd72;
  localparam logic [AW_W-1:0]   AREA_W_RST   = 10'd250;
  localparam logic [AH_W-1:0]   AREA_H_RST   = 10'd48;
  localparam logic [SPAN_W-1:0] MIN_SPAN_RST = 16'd500;

  typedef enum logic [2:0] {
    REG_ORIGIN_X    = 3'd0,
    REG_ORIGIN_Y    = 3'd1,
    REG_AREA_WIDTH  = 3'd2,
    REG_AREA_HEIGHT = 3'd3,
    REG_MIN_SPAN    = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic              start;
    logic [DVD_W-1:0]  dividend;
    logic [SPAN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_rsp_t;

endpackage

[sv/ahgp_if.sv]
// valid/ready channels for the sample word and the vertex word
interface ahgp_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [ahgp_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface ahgp_out_if;
  logic                         valid;
  logic                         ready;
  logic [ahgp_pkg::COORD_W-1:0] px;
  logic [ahgp_pkg::COORD_W-1:0] py;
  logic                         last;

  modport source (output valid, output px, output py, output last, input ready);
  modport sink (input valid, input px, input py, input last, output ready);
endinterface

[sv/autoscaled_history_graph_plotter.sv]
// Sparkline plotter: each sample word goes into a ring of the last HISTORY_DEPTH readings;
// once two or more are held, the block scans them for min and max, widens the span to
// min_span if needed, and sends one vertex word per held reading, oldest first, with last
// set on the newest. Each item runs a min/max scan through the one read port of the history
// memory, a span step, then one pass of the shared restoring divider (ten quotient bits) for
// the x step and one more per vertex for its row, plus a read, a multiply and a load step per
// vertex. in_ch.ready is low while an item is at work; a finished vertex waits in the output
// register.
module autoscaled_history_graph_plotter #(
  parameter int HISTORY_DEPTH = 50
) (
  input  logic                          clk,
  input  logic                          rst,
  ahgp_in_if.sink                       in_ch,
  ahgp_out_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ahgp_pkg::APB_AW-1:0]   paddr,
  input  logic [ahgp_pkg::APB_DW-1:0]   pwdata,
  output logic [ahgp_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import ahgp_pkg::*;

  localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(HISTORY_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(HISTORY_DEPTH);
  localparam logic [CNT_W:0]   DEPTH_X  = (CNT_W + 1)'(HISTORY_DEPTH);

  typedef enum logic [2:0] {
    IDLE,
    SCAN,
    CALC,
    STEPDIV,
    VREAD,
    VMUL,
    VDIV,
    VLOAD
  } state_t;

  // configuration registers
  logic [OX_W-1:0]   origin_x;
  logic [OY_W-1:0]   origin_y;
  logic [AW_W-1:0]   area_width;
  logic [AH_W-1:0]   area_height;
  logic [SPAN_W-1:0] min_span;
  reg_idx_t          widx;

  assign widx   = reg_idx_t'(paddr[APB_AW-1:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x    <= ORIGIN_X_RST;
      origin_y    <= ORIGIN_Y_RST;
      area_width  <= AREA_W_RST;
      area_height <= AREA_H_RST;
      min_span    <= MIN_SPAN_RST;
    end else if (psel && penable && pwrite) begin
      unique case (widx)
        REG_ORIGIN_X:    origin_x    <= pwdata[OX_W-1:0];
        REG_ORIGIN_Y:    origin_y    <= pwdata[OY_W-1:0];
        REG_AREA_WIDTH:  area_width  <= pwdata[AW_W-1:0];
        REG_AREA_HEIGHT: area_height <= pwdata[AH_W-1:0];
        REG_MIN_SPAN:    min_span    <= pwdata[SPAN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      REG_ORIGIN_X:    prdata = APB_DW'(origin_x);
      REG_ORIGIN_Y:    prdata = APB_DW'(origin_y);
      REG_AREA_WIDTH:  prdata = APB_DW'(area_width);
      REG_AREA_HEIGHT: prdata = APB_DW'(area_height);
      REG_MIN_SPAN:    prdata = APB_DW'(min_span);
      default:         prdata = '0;
    endcase
  end

  // sequencer state
  state_t                     state;
  logic [PTR_W-1:0]           wp;
  logic [PTR_W-1:0]           oldest;
  logic [PTR_W-1:0]           addr;
  logic [CNT_W-1:0]           fill;
  logic [CNT_W-1:0]           n;
  logic [CNT_W-1:0]           icnt;
  logic [CNT_W-1:0]           rcnt;
  logic [CNT_W-1:0]           vi;
  logic                       rdv;
  logic signed [SAMPLE_W-1:0] mn;
  logic signed [SAMPLE_W-1:0] mx;
  logic [SPAN_W-1:0]          span;
  logic signed [SAMPLE_W+1:0] lo;
  logic [COORD_W-1:0]         step;
  logic [COORD_W-1:0]         x;
  logic [COORD_W-1:0]         yv;
  logic                       out_valid;
  logic [COORD_W-1:0]         opx;
  logic [COORD_W-1:0]         opy;
  logic                       olast;
  div_req_t                   dreq;
  div_rsp_t                   drsp;

  // history memory
  logic signed [SAMPLE_W-1:0] hist [HISTORY_DEPTH];
  logic signed [SAMPLE_W-1:0] rdata;
  logic                       in_ack;

  assign in_ch.ready = (state == IDLE);
  assign in_ack      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (in_ack) begin
      hist[wp] <= in_ch.sample;
    end
    rdata <= hist[addr];
  end

  ahgp_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  // next pointer, fill and oldest entry for an accepted word
  logic [PTR_W-1:0] wp_next;
  logic [CNT_W-1:0] fill_next;
  logic [CNT_W:0]   old_sum;
  logic [PTR_W-1:0] oldest_next;

  always_comb begin
    wp_next     = (wp == LAST_PTR) ? '0 : wp + 1'b1;
    fill_next   = (fill < DEPTH_C) ? fill + 1'b1 : fill;
    old_sum     = {1'b0, CNT_W'(wp_next)} + DEPTH_X - {1'b0, fill_next};
    oldest_next = (old_sum >= DEPTH_X) ? PTR_W'(old_sum - DEPTH_X) : PTR_W'(old_sum);
  end

  // span and offset
  logic [SPAN_W-1:0]          ms_eff;
  logic signed [SAMPLE_W:0]   span_raw;
  logic signed [SAMPLE_W:0]   sum;
  logic signed [SAMPLE_W:0]   mid;
  logic signed [SAMPLE_W+1:0] lo_mid;
  logic [AW_W-1:0]            aw_m2;

  always_comb begin
    ms_eff   = (min_span == '0) ? SPAN_W'(1) : min_span;
    span_raw = (SAMPLE_W + 1)'(mx) - (SAMPLE_W + 1)'(mn);
    sum      = (SAMPLE_W + 1)'(mx) + (SAMPLE_W + 1)'(mn);
    mid      = (sum + $signed((SAMPLE_W + 1)'(sum[SAMPLE_W]))) >>> 1;
    lo_mid   = (SAMPLE_W + 2)'(mid) - (SAMPLE_W + 2)'({1'b0, ms_eff >> 1});
    aw_m2    = area_width - AW_W'(2);
  end

  // vertex row arithmetic
  logic signed [SAMPLE_W+1:0] dfull;
  logic [SPAN_W-1:0]          d;
  logic                       sneg;
  logic [AH_W-1:0]            abs_scale;
  logic [DVD_W-1:0]           prod;
  logic [COORD_W-1:0]         base_y;

  always_comb begin
    dfull     = (SAMPLE_W + 2)'(rdata) - lo;
    d         = dfull[SPAN_W-1:0];
    sneg      = area_height < AH_W'(4);
    abs_scale = sneg ? AH_W'(4) - area_height : area_height - AH_W'(4);
    prod      = DVD_W'(d) * DVD_W'(abs_scale);
    base_y    = COORD_W'(origin_y) + area_height - COORD_W'(2);
    yv        = sneg ? base_y + drsp.quot : base_y - drsp.quot;
  end

  always_ff @(posedge clk) begin
    dreq.start <= 1'b0;
    if (rst) begin
      state     <= IDLE;
      wp        <= '0;
      fill      <= '0;
      rdv       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ch.ready && state != VLOAD) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (in_ack) begin
            wp     <= wp_next;
            fill   <= fill_next;
            n      <= fill_next;
            oldest <= oldest_next;
            addr   <= oldest_next;
            icnt   <= '0;
            rcnt   <= '0;
            rdv    <= 1'b0;
            if (fill_next >= CNT_W'(2)) begin
              state <= SCAN;
            end
          end
        end
        SCAN: begin
          rdv <= (icnt < n);
          if (icnt < n) begin
            addr <= (addr == LAST_PTR) ? '0 : addr + 1'b1;
            icnt <= icnt + 1'b1;
          end
          if (rdv) begin
            if (rcnt == '0) begin
              mn <= rdata;
              mx <= rdata;
            end else begin
              if (rdata < mn) mn <= rdata;
              if (rdata > mx) mx <= rdata;
            end
            rcnt <= rcnt + 1'b1;
            if (rcnt == n - 1'b1) begin
              state <= CALC;
            end
          end
        end
        CALC: begin
          if (span_raw[SPAN_W-1:0] < ms_eff) begin
            span <= ms_eff;
            lo   <= lo_mid;
          end else begin
            span <= span_raw[SPAN_W-1:0];
            lo   <= (SAMPLE_W + 2)'(mn);
          end
          dreq.start    <= 1'b1;
          dreq.dividend <= DVD_W'(aw_m2);
          dreq.divisor  <= SPAN_W'(n - 1'b1);
          state         <= STEPDIV;
        end
        STEPDIV: begin
          if (drsp.done) begin
            step  <= (area_width < AW_W'(2) || drsp.quot == '0) ? COORD_W'(1) : drsp.quot;
            x     <= COORD_W'(origin_x) + COORD_W'(1);
            vi    <= '0;
            addr  <= oldest;
            state <= VREAD;
          end
        end
        VREAD: begin
          state <= VMUL;
        end
        VMUL: begin
          dreq.start    <= 1'b1;
          dreq.dividend <= prod;
          dreq.divisor  <= span;
          addr          <= (addr == LAST_PTR) ? '0 : addr + 1'b1;
          state         <= VDIV;
        end
        VDIV: begin
          if (drsp.done) begin
            state <= VLOAD;
          end
        end
        VLOAD: begin
          if (!out_valid || out_ch.ready) begin
            out_valid <= 1'b1;
            opx       <= x;
            opy       <= yv;
            olast     <= (vi == n - 1'b1);
            x         <= x + step;
            vi        <= vi + 1'b1;
            state     <= (vi == n - 1'b1) ? IDLE : VREAD;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.px    = opx;
  assign out_ch.py    = opy;
  assign out_ch.last  = olast;

endmodule

[sv/ahgp_div.sv]
// restoring divider, one quotient bit per cycle, quotient known to fit QUOT_W bits
module ahgp_div (
  input  logic               clk,
  input  logic               rst,
  input  ahgp_pkg::div_req_t req,
  output ahgp_pkg::div_rsp_t rsp
);
  import ahgp_pkg::*;

  localparam int CNT_W = $clog2(QUOT_W + 1);

  logic [SPAN_W-1:0] rem;
  logic [SPAN_W-1:0] dvs;
  logic [QUOT_W-1:0] sh;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic              done;
  logic [SPAN_W:0]   trial;
  logic [SPAN_W:0]   diff;
  logic              ge;

  assign trial = {rem, sh[QUOT_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      rem  <= req.dividend[DVD_W-1:QUOT_W];
      sh   <= req.dividend[QUOT_W-1:0];
      dvs  <= req.divisor;
      cnt  <= CNT_W'(QUOT_W);
      busy <= 1'b1;
    end else if (busy) begin
      rem <= ge ? diff[SPAN_W-1:0] : trial[SPAN_W-1:0];
      sh  <= {sh[QUOT_W-2:0], ge};
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = sh;

endmodule
